>>> hdl/sfs_pkg.sv
// Shared types, codes and default sizes for the sprite frame sequencer.
package sfs_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_FRAMES_DEF = 256;
  localparam int TICK_RATE_DEF  = 60;
  localparam int TICK_W_DEF     = $clog2(TICK_RATE_DEF + 1);
  localparam int RATE_W         = 7;
  localparam int CFG_DATA_W     = 16;

  // Input item actions
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_PLAY  = 2'd1,
    ACT_PAUSE = 2'd2,
    ACT_SET   = 2'd3
  } action_t;

  // Play modes (code 3 behaves as loop)
  localparam logic [1:0] MODE_LOOP     = 2'd0;
  localparam logic [1:0] MODE_PINGPONG = 2'd1;
  localparam logic [1:0] MODE_STOP     = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_PLAY_MODE    = 2'd0;
  localparam logic [1:0] REG_FIRST_SPRITE = 2'd1;
  localparam logic [1:0] REG_LAST_SPRITE  = 2'd2;
  localparam logic [1:0] REG_FRAME_RATE   = 2'd3;

  localparam logic signed [RATE_W-1:0] RATE_RESET = 7'sd10;

endpackage

>>> hdl/sprite_frame_sequencer.sv
// Sprite frame sequencer top level: frame stepping, modes and item handshake.
//
// Input channel (in_valid / in_stall): one item per display event, action
// tick, play, pause or set frame, with frame_value used by set frame.
// Output channel (out_valid / out_stall): exactly one result item per input
// item, carrying sprite_index, frame_now, is_playing and finished for the
// state after that item.
// Configuration channel (cfg_valid / cfg_ready): register index and data;
// ready only while the sequencer sits idle with no input item offered.
// Each accepted item runs the divider for TICK_RATE/|frame_rate| in TW
// steps, where TW = $clog2(TICK_RATE + 1); the divider then passes on its
// done flag, the state is updated and the output register is loaded. The
// next item is taken once the result sits in the output register, which
// may still wait for the receiver, so the block takes no new item before
// it is through with the last one.
// While out_stall is high the result holds, and a finished item waits for
// the output register before the block turns ready again.
// Reset (rst, synchronous) clears the pipeline, pauses playback at frame 0
// and loads mode loop, sprites 0..0 and a rate of 10.
module sprite_frame_sequencer import sfs_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int TICK_RATE  = TICK_RATE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            action,
  input  logic signed [15:0]    frame_value,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           sprite_index,
  output logic [7:0]            frame_now,
  output logic                  is_playing,
  output logic                  finished,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FW = $clog2(MAX_FRAMES);
  localparam int TW = $clog2(TICK_RATE + 1);
  localparam logic [16:0] TOP_MAX = 17'(MAX_FRAMES - 1);
  localparam logic [TW-1:0] TR = TW'(TICK_RATE);
  localparam logic signed [8:0] RLIM_P = 9'(TICK_RATE);
  localparam logic signed [8:0] RLIM_N = 9'(-TICK_RATE);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_APPLY = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t st;

  // configuration registers
  logic [1:0]               play_mode;
  logic [15:0]              first_sprite;
  logic [15:0]              last_sprite;
  logic signed [RATE_W-1:0] frame_rate;

  // playback state
  logic          running;
  logic [FW-1:0] current_frame;
  logic [TW-1:0] tick_countdown;
  logic          reversed_flag;
  logic          done_flag;

  // latched item
  action_t       act;
  logic [15:0]   fval;

  logic          div_start;
  logic          div_done;
  logic [TW-1:0] reload;
  logic [RATE_W-1:0] rate_abs;

  // Highest frame index for a sprite range, clamped to 0..MAX_FRAMES-1
  function automatic logic [FW-1:0] calc_top(input logic [15:0] f, input logic [15:0] l);
    logic [16:0] d;
    d = {1'b0, l} - {1'b0, f};
    if (d[16]) return '0;
    else if (d >= TOP_MAX) return FW'(TOP_MAX);
    else return FW'(d);
  endfunction

  // Frame arithmetic on the current state
  logic [FW-1:0] top;
  logic          rate_neg;
  logic          rate_zero;
  logic          at_end;
  logic          looping;
  logic signed [8:0] rate_wr;
  logic [FW-1:0] top_first_wr;
  logic [FW-1:0] top_last_wr;

  always_comb begin
    top       = calc_top(first_sprite, last_sprite);
    rate_neg  = frame_rate[RATE_W-1];
    rate_zero = (frame_rate == '0);
    at_end    = (reversed_flag ^ rate_neg) ? (current_frame == '0) : (current_frame == top);
    looping   = (play_mode != MODE_PINGPONG) && (play_mode != MODE_STOP);
    rate_abs  = rate_neg ? RATE_W'(-frame_rate) : RATE_W'(frame_rate);
    rate_wr   = 9'(signed'(cfg_data[RATE_W-1:0]));
    top_first_wr = calc_top(cfg_data, last_sprite);
    top_last_wr  = calc_top(first_sprite, cfg_data);
  end

  // Next playback state for the latched item
  logic          running_next;
  logic [FW-1:0] frame_next;
  logic [TW-1:0] countdown_next;
  logic          reversed_next;
  logic          done_next;
  logic          back_next;

  always_comb begin
    running_next   = running;
    frame_next     = current_frame;
    countdown_next = tick_countdown;
    reversed_next  = reversed_flag;
    done_next      = 1'b0;
    back_next      = reversed_flag ^ rate_neg;
    unique case (act)
      ACT_TICK: begin
        if (running && !rate_zero) begin
          if (tick_countdown > TW'(1)) begin
            countdown_next = tick_countdown - TW'(1);
          end else if (at_end && play_mode == MODE_STOP) begin
            running_next   = 1'b0;
            countdown_next = '0;
            done_next      = 1'b1;
          end else begin
            if (at_end && play_mode == MODE_PINGPONG) reversed_next = ~reversed_flag;
            back_next = reversed_next ^ rate_neg;
            if (top != '0) begin
              if (!back_next) begin
                if (current_frame >= top) frame_next = looping ? '0 : top;
                else frame_next = current_frame + FW'(1);
              end else begin
                if (current_frame == '0) frame_next = looping ? top : '0;
                else frame_next = current_frame - FW'(1);
              end
            end
            countdown_next = reload;
          end
        end
      end
      ACT_PLAY: begin
        if (!running) begin
          running_next = 1'b1;
          if (rate_zero) begin
            countdown_next = '0;
          end else begin
            countdown_next = reload;
            if (play_mode == MODE_STOP && at_end) begin
              frame_next = (current_frame == '0) ? top : '0;
            end
          end
        end
      end
      ACT_PAUSE: begin
        running_next = 1'b0;
      end
      ACT_SET: begin
        if (fval[15]) frame_next = '0;
        else if (fval > 16'(top)) frame_next = top;
        else frame_next = FW'(fval);
      end
      default: begin
        running_next = running;
      end
    endcase
  end

  // Shared divider for the countdown reload
  assign div_start = in_valid && !in_stall;

  sfs_div #(
    .NW (TW),
    .DW (RATE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (TR),
    .divisor  (rate_abs),
    .done     (div_done),
    .quotient (reload)
  );

  assign in_stall  = (st != S_IDLE);
  assign cfg_ready = (st == S_IDLE) && !in_valid;

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // Sequencer, state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= S_IDLE;
      play_mode      <= MODE_LOOP;
      first_sprite   <= '0;
      last_sprite    <= '0;
      frame_rate     <= RATE_RESET;
      running        <= 1'b0;
      current_frame  <= '0;
      tick_countdown <= '0;
      reversed_flag  <= 1'b0;
      done_flag      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (st == S_EMIT && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (in_valid) st <= S_DIV;
          if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
              REG_PLAY_MODE: begin
                play_mode <= cfg_data[1:0];
                if (cfg_data[1:0] != MODE_PINGPONG) reversed_flag <= 1'b0;
              end
              REG_FIRST_SPRITE: begin
                first_sprite <= cfg_data;
                if (current_frame > top_first_wr) current_frame <= top_first_wr;
              end
              REG_LAST_SPRITE: begin
                last_sprite <= cfg_data;
                if (current_frame > top_last_wr) current_frame <= top_last_wr;
              end
              REG_FRAME_RATE: begin
                if (rate_wr > RLIM_P) frame_rate <= RATE_W'(RLIM_P);
                else if (rate_wr < RLIM_N) frame_rate <= RATE_W'(RLIM_N);
                else frame_rate <= cfg_data[RATE_W-1:0];
              end
              default: begin
                play_mode <= play_mode;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) st <= S_APPLY;
        end
        S_APPLY: begin
          running        <= running_next;
          current_frame  <= frame_next;
          tick_countdown <= countdown_next;
          reversed_flag  <= reversed_next;
          done_flag      <= done_next;
          st             <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  // Item latch and result payload
  always_ff @(posedge clk) begin
    if (div_start) begin
      act  <= action_t'(action);
      fval <= frame_value[15:0];
    end
    if (st == S_EMIT && out_free) begin
      sprite_index <= first_sprite + 16'(current_frame);
      frame_now    <= 8'(current_frame);
      is_playing   <= running;
      finished     <= done_flag;
    end
  end

endmodule

>>> hdl/sfs_div.sv
// Restoring serial divider, one quotient bit per cycle.
module sfs_div import sfs_pkg::*; #(
  parameter int NW = TICK_W_DEF,
  parameter int DW = RATE_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNT_W = $clog2(NW + 1);

  logic          busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [NW-1:0] quo;

  logic [DW:0]   trial;
  logic          fits;
  logic [DW:0]   diff;

  // One trial subtraction per cycle
  always_comb begin
    trial = {rem, quo[NW-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo <= NW'({quo, fits});
    end
  end

  assign quotient = quo;

endmodule
